FILE: design/bal_pkg.sv
package bal_pkg;

    localparam int CAPACITY_ENTRIES = 64;
    localparam int ELEMENT_BITS     = 32;
    localparam int IDX_BITS         = $clog2(CAPACITY_ENTRIES);
    localparam int LEN_BITS         = $clog2(CAPACITY_ENTRIES + 1);

    typedef logic signed [ELEMENT_BITS-1:0] elem_t;
    typedef logic [LEN_BITS-1:0]            len_t;
    typedef logic [IDX_BITS-1:0]            idx_t;

    typedef enum logic [3:0] {
        REQ_CLEAR     = 4'd0,
        REQ_INS_FIRST = 4'd1,
        REQ_INS_AT    = 4'd2,
        REQ_INS_LAST  = 4'd3,
        REQ_DEL_FIRST = 4'd4,
        REQ_DEL_AT    = 4'd5,
        REQ_DEL_LAST  = 4'd6,
        REQ_FIND      = 4'd7,
        REQ_SORT      = 4'd8,
        REQ_EXTREMES  = 4'd9,
        REQ_READ      = 4'd10
    } req_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_DELETE,
        OP_SORT
    } cell_op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SORT,
        S_SCAN,
        S_DONE
    } state_t;

    // Broadcast to every cell.
    typedef struct packed {
        cell_op_t op;
        idx_t     pos;
        elem_t    value;
        logic     desc;
        logic     odd_phase;
    } cell_ctrl_t;

endpackage

FILE: design/bal_cell.sv
module bal_cell
    import bal_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  idx_t       my_index,
    input  elem_t      left_value,
    input  elem_t      right_value,
    output elem_t      value
);

    elem_t value_reg;
    elem_t value_next;
    logic  is_upper;
    logic  swap_lo;
    logic  swap_hi;
    logic  pair_ok;

    assign value = value_reg;

    // Pair (2k,2k+1) on even phase, (2k+1,2k+2) on odd phase.
    // During sort ctrl.pos holds the last live index; pairs past it stay idle.
    assign is_upper = my_index[0] ^ ctrl.odd_phase;
    assign swap_lo  = ctrl.desc ? (right_value > value_reg) : (right_value < value_reg);
    assign swap_hi  = ctrl.desc ? (value_reg > left_value) : (value_reg < left_value);
    assign pair_ok  = is_upper ? ((my_index != '0) && (my_index <= ctrl.pos))
                               : (my_index < ctrl.pos);

    always_comb
    begin
        value_next = value_reg;
        unique case (ctrl.op)
            OP_HOLD:
                value_next = value_reg;
            OP_INSERT:
            begin
                if (my_index == ctrl.pos)
                    value_next = ctrl.value;
                else if (my_index > ctrl.pos)
                    value_next = left_value;
            end
            OP_DELETE:
            begin
                if (my_index >= ctrl.pos)
                    value_next = right_value;
            end
            OP_SORT:
            begin
                if (pair_ok)
                begin
                    if (is_upper && swap_hi)
                        value_next = left_value;
                    else if (!is_upper && swap_lo)
                        value_next = right_value;
                end
            end
            default:
                value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

FILE: design/bal_chain.sv
module bal_chain
    import bal_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    output elem_t      cell_value [CAPACITY_ENTRIES]
);

    genvar g;
    generate
        for (g = 0; g < CAPACITY_ENTRIES; g++)
        begin : g_cell
            elem_t left_v;
            elem_t right_v;
            if (g == 0)
            begin : g_first
                assign left_v = cell_value[0];
            end
            else
            begin : g_mid
                assign left_v = cell_value[g-1];
            end
            if (g == CAPACITY_ENTRIES - 1)
            begin : g_last
                assign right_v = cell_value[g];
            end
            else
            begin : g_rest
                assign right_v = cell_value[g+1];
            end
            bal_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .my_index    (idx_t'(g)),
                .left_value  (left_v),
                .right_value (right_v),
                .value       (cell_value[g])
            );
        end
    endgenerate

endmodule

FILE: design/bounded_array_list.sv
// Bounded array list of 64 signed 32-bit words held in a chain of cells, each
// cell one entry. One request at a time. Inserts, deletes, clear and read
// do their work as the request is accepted, then give the result from S_DONE;
// find and extremes step a scan pointer across the list, one entry per cycle;
// sort runs odd-even transposition passes over the live cells, one pass per
// cycle, length passes. The result is held in an output register until
// taken; the next request is accepted meanwhile and its result waits behind.
module bounded_array_list
    import bal_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [3:0]              req_type,
    input  logic signed [31:0]      item_value,
    input  logic [5:0]              position,
    input  logic                    descending,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [2:0]              status,
    output logic signed [31:0]      out_value,
    output logic signed [31:0]      smallest,
    output logic [5:0]              found_index,
    output logic [6:0]              list_length
);

    state_t  state_reg, state_next;
    len_t    count_reg, count_next;
    len_t    step_reg, step_next;
    logic [3:0] req_reg, req_next;
    elem_t   val_reg, val_next;
    logic    desc_reg, desc_next;
    logic    found_reg, found_next;
    status_t st_reg, st_next;
    elem_t   ov_reg, ov_next;
    elem_t   sm_reg, sm_next;
    idx_t    fi_reg, fi_next;
    logic    out_valid_reg, out_valid_next;
    status_t res_status_reg, res_status_next;
    elem_t   res_value_reg, res_value_next;
    elem_t   res_small_reg, res_small_next;
    idx_t    res_index_reg, res_index_next;
    len_t    res_len_reg, res_len_next;

    cell_ctrl_t ctrl;
    elem_t      cell_value [CAPACITY_ENTRIES];
    elem_t      scan_value;
    elem_t      val_in;
    idx_t       pos_in;
    len_t       pos_len;
    logic       accept;
    logic       full;

    bal_chain u_chain (
        .clk        (clk),
        .ctrl       (ctrl),
        .cell_value (cell_value)
    );

    assign accept     = in_valid && !in_stall;
    assign in_stall   = (state_reg != S_IDLE);
    assign val_in     = elem_t'(item_value);
    assign pos_in     = idx_t'(position);
    assign pos_len    = len_t'(position);
    assign full       = count_reg >= len_t'(CAPACITY_ENTRIES);
    assign scan_value = cell_value[step_reg[IDX_BITS-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg       <= step_next;
        req_reg        <= req_next;
        val_reg        <= val_next;
        desc_reg       <= desc_next;
        found_reg      <= found_next;
        st_reg         <= st_next;
        ov_reg         <= ov_next;
        sm_reg         <= sm_next;
        fi_reg         <= fi_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        res_small_reg  <= res_small_next;
        res_index_reg  <= res_index_next;
        res_len_reg    <= res_len_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        step_next       = step_reg;
        req_next        = req_reg;
        val_next        = val_reg;
        desc_next       = desc_reg;
        found_next      = found_reg;
        st_next         = st_reg;
        ov_next         = ov_reg;
        sm_next         = sm_reg;
        fi_next         = fi_reg;
        out_valid_next  = out_valid_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        res_small_next  = res_small_reg;
        res_index_next  = res_index_reg;
        res_len_next    = res_len_reg;
        ctrl.op         = OP_HOLD;
        ctrl.pos        = '0;
        ctrl.value      = val_in;
        ctrl.desc       = desc_reg;
        ctrl.odd_phase  = step_reg[0];

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next   = req_type;
                    val_next   = val_in;
                    desc_next  = descending;
                    st_next    = ST_OK;
                    ov_next    = '0;
                    sm_next    = '0;
                    fi_next    = '0;
                    step_next  = '0;
                    found_next = 1'b0;
                    state_next = S_DONE;
                    unique case (req_type)
                        REQ_CLEAR:
                            count_next = '0;
                        REQ_INS_FIRST, REQ_INS_AT, REQ_INS_LAST:
                        begin
                            if (full)
                                st_next = ST_FULL;
                            else if (req_type == REQ_INS_AT && pos_len > count_reg)
                                st_next = ST_BADPOS;
                            else
                            begin
                                ctrl.op = OP_INSERT;
                                if (req_type == REQ_INS_AT)
                                    ctrl.pos = pos_in;
                                else if (req_type == REQ_INS_LAST)
                                    ctrl.pos = count_reg[IDX_BITS-1:0];
                                count_next = count_reg + len_t'(1);
                            end
                        end
                        REQ_DEL_FIRST, REQ_DEL_AT, REQ_DEL_LAST:
                        begin
                            if (count_reg == '0)
                                st_next = ST_EMPTY;
                            else if (req_type == REQ_DEL_AT && pos_len >= count_reg)
                                st_next = ST_BADPOS;
                            else
                            begin
                                ctrl.op = OP_DELETE;
                                if (req_type == REQ_DEL_AT)
                                    ctrl.pos = pos_in;
                                else if (req_type == REQ_DEL_LAST)
                                    ctrl.pos = idx_t'(count_reg - len_t'(1));
                                ov_next    = cell_value[ctrl.pos];
                                count_next = count_reg - len_t'(1);
                            end
                        end
                        REQ_FIND:
                        begin
                            st_next    = ST_NOTFOUND;
                            state_next = S_SCAN;
                        end
                        REQ_EXTREMES:
                        begin
                            if (count_reg == '0)
                                st_next = ST_EMPTY;
                            else
                            begin
                                ov_next    = cell_value[0];
                                sm_next    = cell_value[0];
                                step_next  = len_t'(1);
                                state_next = S_SCAN;
                            end
                        end
                        REQ_SORT:
                            state_next = S_SORT;
                        REQ_READ:
                        begin
                            if (count_reg == '0)
                                st_next = ST_EMPTY;
                            else if (pos_len >= count_reg)
                                st_next = ST_BADPOS;
                            else
                                ov_next = cell_value[pos_in];
                        end
                        default:
                            st_next = ST_OK;
                    endcase
                end
            end
            S_SORT:
            begin
                // Pairs are limited to the live entries below count.
                if (step_reg >= count_reg)
                    state_next = S_DONE;
                else
                begin
                    ctrl.op   = OP_SORT;
                    ctrl.pos  = idx_t'(count_reg - len_t'(1));
                    step_next = step_reg + len_t'(1);
                end
            end
            S_SCAN:
            begin
                if (step_reg >= count_reg || found_reg)
                    state_next = S_DONE;
                else
                begin
                    step_next = step_reg + len_t'(1);
                    if (req_reg == REQ_FIND)
                    begin
                        if (scan_value == val_reg)
                        begin
                            found_next = 1'b1;
                            st_next    = ST_OK;
                            fi_next    = step_reg[IDX_BITS-1:0];
                        end
                    end
                    else
                    begin
                        if (scan_value > ov_reg)
                            ov_next = scan_value;
                        if (scan_value < sm_reg)
                            sm_next = scan_value;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    res_status_next = st_reg;
                    res_value_next  = ov_reg;
                    res_small_next  = sm_reg;
                    res_index_next  = fi_reg;
                    res_len_next    = count_reg;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign status      = res_status_reg;
    assign out_value   = res_value_reg;
    assign smallest    = res_small_reg;
    assign found_index = res_index_reg;
    assign list_length = res_len_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= len_t'(CAPACITY_ENTRIES))
        else $error("length above capacity");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("input taken while busy");

    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SORT || state_reg == S_SCAN) |=> $stable(count_reg))
        else $error("length changed during sort or scan");

endmodule
